// File: sv/sgm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_pkg: shared types and constants for the sobel gradient magnitude block
// Holds the job and result records and the configuration register indexes.
// ---------------------------------------------------------------------------
package sgm_pkg;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // register reset values and limits
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] ROW_LIMIT    = 13'd4096;

  // one gradient job handed from the front to the back
  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [11:0]        col;
    logic [11:0]        row;
    logic               last;
    logic               eop;
  } sgm_job_t;

  // one finished result
  typedef struct packed {
    logic [7:0]  mag;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic        eop;
  } sgm_res_t;

endpackage

// File: sv/sobel_gradient_magnitude.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_gradient_magnitude: streaming 3x3 sobel edge magnitude
// Line stores, window, gradient jobs and a sequential root unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive sample_i with push; a transfer happens when push is
//   high and full is low. Samples of one plane come in raster order.
//   Result queue: while empty is low the oldest result is on the result
//   ports; pop takes it. Each sample causes zero to four results, the last
//   one flagged by last_of_run_o; end_of_plane_o marks the final pixel.
//   Configuration: cfg_we_i writes image_width (index 0) or image_height
//   (index 1) and restarts the plane at row 0, column 0; write only idle.
// Timing:
//   The front takes no new sample until it has issued every job that the
//   sample causes, one job per cycle while the job queue is not full. The
//   back takes one job at a time, set by the one-bit-per-cycle square root,
//   and takes a new job only after its last result has left it.
// Reset clears position, window and queues and loads 640 x 480. A stalled
//   receiver fills the result queue, then the job queue, then raises full.
// ---------------------------------------------------------------------------
module sobel_gradient_magnitude import sgm_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  magnitude_o,
  output logic [11:0] out_col_o,
  output logic [11:0] out_row_o,
  output logic        last_of_run_o,
  output logic        end_of_plane_o
);

  localparam int JW = $bits(sgm_job_t);
  localparam int RW = $bits(sgm_res_t);

  sgm_job_t job_in, job_out, job_head;
  sgm_res_t res_in, res_head;
  logic     job_push, job_full, job_pop, job_empty;
  logic     res_push, res_full;
  logic [JW-1:0] job_flat;
  logic [RW-1:0] res_flat;

  // front: intake and job generation
  sgm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .job_o       (job_in),
    .job_push_o  (job_push),
    .job_full_i  (job_full)
  );

  // job queue between front and back
  sgm_fifo #(.DW(JW), .DEPTH(4)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_flat),
    .empty_o (job_empty)
  );

  assign job_head = sgm_job_t'(job_flat);
  assign job_out  = job_head;

  // back: magnitude
  sgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue toward the receiver
  sgm_fifo #(.DW(RW), .DEPTH(4)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_flat),
    .empty_o (empty)
  );

  assign res_head       = sgm_res_t'(res_flat);
  assign magnitude_o    = res_head.mag;
  assign out_col_o      = res_head.col;
  assign out_row_o      = res_head.row;
  assign last_of_run_o  = res_head.last;
  assign end_of_plane_o = res_head.eop;

endmodule

// File: sv/sgm_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_fifo: small register queue
// Flat data word, push/full on the write side, pop/empty on the read side.
// ---------------------------------------------------------------------------
module sgm_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] data_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = data_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

// File: sv/sgm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_front: sample intake, line stores, window and gradient jobs
// Takes one sample, reads both line stores, then issues up to four gradient
// jobs (lower row first, lower column first) into the job queue.
// ---------------------------------------------------------------------------
module sgm_front import sgm_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_i,
  output sgm_job_t    job_o,
  output logic        job_push_o,
  input  logic        job_full_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(2 * MAX_WIDTH);
  localparam int DEPTH = 2 * MAX_WIDTH;

  typedef enum logic {ST_IDLE, ST_GEN} state_e;

  state_e        state_q;
  logic [12:0]   width_q, height_q;
  logic [CW-1:0] col_q, c_q;
  logic [11:0]   row_q, r_q;
  logic [7:0]    sample_q, rd_prev_q, rd_old_q;
  logic          c_ge1_q, c_ge2_q, r0_q, rle1_q;
  logic [3:0]    pend_q;
  logic [7:0]    win_q [6];
  logic [7:0]    line_mem [DEPTH];

  logic [WW-1:0] w_use, col_inc;
  logic [12:0]   h_use, row_inc;
  logic          accept, col_wrap, row_wrap;
  logic [AW-1:0] a_old, a_prev;
  logic [7:0]    cur [3];
  logic [7:0]    lc [3];
  logic [7:0]    mc [3];
  logic [7:0]    rc [3];
  logic [1:0]    sel;
  logic [3:0]    sel_bit;
  logic [3:0]    pend_a;
  logic [7:0]    lt, lm, lb, mt, mb, rt, rm, rb;

  function automatic logic signed [10:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    logic [10:0] s;
    s = 11'(a) + {2'b00, b, 1'b0} + 11'(c);
    return $signed(s);
  endfunction

  // clamp the configured frame size
  always_comb begin
    if (width_q == 13'd0) begin
      w_use = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(width_q);
    end
    if (height_q == 13'd0) begin
      h_use = 13'd1;
    end else if (height_q > ROW_LIMIT) begin
      h_use = ROW_LIMIT;
    end else begin
      h_use = height_q;
    end
  end

  assign accept   = push && !full;
  assign full     = (state_q != ST_IDLE);
  assign col_inc  = WW'(col_q) + WW'(1);
  assign col_wrap = (col_inc >= w_use);
  assign row_inc  = {1'b0, row_q} + 13'd1;
  assign row_wrap = (row_inc >= h_use);

  // line store addresses: the row parity picks the half
  assign a_old  = row_q[0] ? AW'(MAX_WIDTH) + AW'(col_q) : AW'(col_q);
  assign a_prev = row_q[0] ? AW'(col_q) : AW'(MAX_WIDTH) + AW'(col_q);

  // pending jobs: prev row then last row, each left column then flush column
  always_comb begin
    logic c_last, r_ge1, r_last, c_ge1;
    c_last = (WW'(col_q) == w_use - WW'(1));
    c_ge1  = (col_q != '0);
    r_ge1  = (row_q != '0);
    r_last = ({1'b0, row_q} == h_use - 13'd1);
    pend_a = {r_last & c_last, r_last & c_ge1, r_ge1 & c_last, r_ge1 & c_ge1};
  end

  // line store: read both rows and write the new sample in the same cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_old_q       <= line_mem[a_old];
      rd_prev_q      <= line_mem[a_prev];
      line_mem[a_old] <= sample_i;
    end
  end

  // current column with top-border replication
  always_comb begin
    cur[2] = sample_q;
    cur[1] = r0_q ? sample_q : rd_prev_q;
    cur[0] = rle1_q ? cur[1] : rd_old_q;
  end

  // pick the oldest pending job
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_bit = 4'b0001 << sel;
  end

  // window columns for the selected job, left- and right-border replication
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!sel[0]) begin
        lc[i] = c_ge2_q ? win_q[3+i] : win_q[i];
        mc[i] = win_q[i];
      end else begin
        lc[i] = c_ge1_q ? win_q[i] : cur[i];
        mc[i] = cur[i];
      end
      rc[i] = cur[i];
    end
    // bottom-border rows repeat the last line
    lt = sel[1] ? lc[1] : lc[0];
    lm = sel[1] ? lc[2] : lc[1];
    lb = lc[2];
    mt = sel[1] ? mc[1] : mc[0];
    mb = mc[2];
    rt = sel[1] ? rc[1] : rc[0];
    rm = sel[1] ? rc[2] : rc[1];
    rb = rc[2];
  end

  // job record
  always_comb begin
    job_o.gx   = wsum(rt, rm, rb) - wsum(lt, lm, lb);
    job_o.gy   = wsum(lb, mb, rb) - wsum(lt, mt, rt);
    job_o.col  = 12'(c_q) - {11'b0, ~sel[0]};
    job_o.row  = r_q - {11'b0, ~sel[1]};
    job_o.last = ((pend_q & ~sel_bit) == 4'b0000);
    job_o.eop  = (sel == 2'd3);
    job_push_o = (state_q == ST_GEN) && (pend_q != 4'b0000) && !job_full_i;
  end

  // control, position counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_we_i) begin
            case (cfg_index_i)
              CFG_WIDTH:  width_q  <= cfg_data_i;
              CFG_HEIGHT: height_q <= cfg_data_i;
              default:    width_q  <= cfg_data_i;
            endcase
            col_q <= '0;
            row_q <= '0;
          end else if (accept) begin
            pend_q  <= pend_a;
            state_q <= ST_GEN;
            if (col_wrap) begin
              col_q <= '0;
              row_q <= row_wrap ? 12'd0 : row_q + 12'd1;
            end else begin
              col_q <= col_q + CW'(1);
            end
          end
        end
        ST_GEN: begin
          if (pend_q == 4'b0000) begin
            for (int i = 0; i < 3; i++) begin
              win_q[3+i] <= win_q[i];
              win_q[i]   <= cur[i];
            end
            state_q <= ST_IDLE;
          end else if (!job_full_i) begin
            pend_q <= pend_q & ~sel_bit;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // snapshot of the accepted sample and its position
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      c_q      <= col_q;
      r_q      <= row_q;
      c_ge1_q  <= (col_q != '0);
      c_ge2_q  <= (col_q > CW'(1));
      r0_q     <= (row_q == 12'd0);
      rle1_q   <= (row_q <= 12'd1);
    end
  end

endmodule

// File: sv/sgm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_back: gradient energy and saturating square root
// Squares gx and gy, sums them, then finds the root one bit per cycle.
// ---------------------------------------------------------------------------
module sgm_back import sgm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sgm_job_t job_i,
  input  logic     job_empty_i,
  output logic     job_pop_o,
  output sgm_res_t res_o,
  output logic     res_push_o,
  input  logic     res_full_i
);

  typedef enum logic [2:0] {ST_IDLE, ST_SQUARE, ST_SUM, ST_ROOT, ST_EMIT} state_e;

  state_e          state_q;
  sgm_job_t        job_q;
  logic [19:0]     sqx_q, sqy_q;
  logic [20:0]     e_q;
  logic [7:0]      root_q;
  logic [2:0]      bit_q;
  logic signed [21:0] px, py;
  logic [7:0]      trial;
  logic [15:0]     trial_sq;

  assign px       = job_q.gx * job_q.gx;
  assign py       = job_q.gy * job_q.gy;
  assign trial    = root_q | (8'd1 << bit_q);
  assign trial_sq = trial * trial;

  assign job_pop_o  = (state_q == ST_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == ST_EMIT) && !res_full_i;

  always_comb begin
    res_o.mag  = root_q;
    res_o.col  = job_q.col;
    res_o.row  = job_q.row;
    res_o.last = job_q.last;
    res_o.eop  = job_q.eop;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sqx_q   <= px[19:0];
          sqy_q   <= py[19:0];
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          e_q     <= 21'(sqx_q) + 21'(sqy_q);
          root_q  <= '0;
          bit_q   <= 3'd7;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          // energy at or above 2^16 saturates
          if (e_q[20:16] != 5'd0) begin
            root_q  <= 8'd255;
            state_q <= ST_EMIT;
          end else begin
            if (trial_sq <= e_q[15:0]) begin
              root_q <= trial;
            end
            bit_q <= bit_q - 3'd1;
            if (bit_q == 3'd0) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/sgm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgm_checker: port-level checks for the sobel gradient magnitude block
// Watches the queue ports and the result flags over time.
// ---------------------------------------------------------------------------
module sgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] magnitude_o,
  input logic       last_of_run_o,
  input logic       end_of_plane_o
);

  // a transfer keeps the intake busy for at least the next cycle
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("intake took a second sample back to back");

  // the final pixel of a plane always closes its run
  a_eop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_plane_o) |-> last_of_run_o)
    else $error("end of plane without last of run");

  // queue status flags are always known once out of reset
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty}))
    else $error("queue status flag unknown");

  // a waiting result holds while the receiver stalls
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(magnitude_o)))
    else $error("stalled result changed");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .magnitude_o    (magnitude_o),
  .last_of_run_o  (last_of_run_o),
  .end_of_plane_o (end_of_plane_o)
);
